// ----- rtl/core/bchr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the button click/hold/repeat core.
// No dependencies; every other file refers to this package by scoped names.
package bchr_pkg;

   localparam int DEFAULT_BUTTONS = 5;
   localparam int NOW_W           = 32;
   localparam int PERIOD_W        = 8;
   localparam int TIME_CFG_W      = 16;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 16;

   localparam logic [PERIOD_W-1:0]   RESET_SAMPLE_PERIOD = 8'd5;
   localparam logic [TIME_CFG_W-1:0] RESET_DEBOUNCE      = 16'd30;
   localparam logic [TIME_CFG_W-1:0] RESET_HOLD          = 16'd600;
   localparam logic [TIME_CFG_W-1:0] RESET_REPEAT        = 16'd100;
   localparam int                    RESET_REPEAT_EN     = 7;
   localparam int                    RESET_HOLD_ACT      = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_PERIOD = 3'd0,
      CSR_DEBOUNCE      = 3'd1,
      CSR_HOLD          = 3'd2,
      CSR_REPEAT        = 3'd3,
      CSR_REPEAT_EN     = 3'd4,
      CSR_HOLD_ACT      = 3'd5
   } csr_index_type;

   // Timing thresholds shared by all lanes
   typedef struct packed {
      logic [PERIOD_W-1:0]   sample_period;
      logic [TIME_CFG_W-1:0] debounce;
      logic [TIME_CFG_W-1:0] hold;
      logic [TIME_CFG_W-1:0] repeat_ival;
   } cfg_type;

   // What one lane reports to the merge stage
   typedef struct packed {
      logic click;
      logic hold;
      logic deb_cur;
      logic deb_next;
   } lane_res_type;

endpackage

// ----- rtl/core/bchr_req_if.sv -----
`timescale 1ns / 1ps
// Input channel: timestamp and pressed vector with valid/ready.
// Depends on bchr_pkg for the default button count.
interface bchr_req_if #(
   parameter int BUTTONS = bchr_pkg::DEFAULT_BUTTONS
);
   logic                        valid;
   logic                        ready;
   logic [bchr_pkg::NOW_W-1:0]  now_ms;
   logic [BUTTONS-1:0]          pressed;

   modport source (output valid, output now_ms, output pressed, input ready);
   modport sink   (input valid, input now_ms, input pressed, output ready);
endinterface

// ----- rtl/core/bchr_rsp_if.sv -----
`timescale 1ns / 1ps
// Result channel: sampled flag and per-button event vectors with valid/ready.
// Depends on bchr_pkg for the default button count.
interface bchr_rsp_if #(
   parameter int BUTTONS = bchr_pkg::DEFAULT_BUTTONS
);
   logic               valid;
   logic               ready;
   logic               sampled;
   logic [BUTTONS-1:0] click_events;
   logic [BUTTONS-1:0] hold_events;
   logic [BUTTONS-1:0] debounced_now;

   modport source (output valid, output sampled, output click_events,
                   output hold_events, output debounced_now, input ready);
   modport sink   (input valid, input sampled, input click_events,
                   input hold_events, input debounced_now, output ready);
endinterface

// ----- rtl/core/bchr_csr_if.sv -----
`timescale 1ns / 1ps
// Configuration write channel: register index and write data with valid/ready.
// Depends on bchr_pkg for field widths.
interface bchr_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bchr_pkg::CSR_IDX_W-1:0]  reg_index;
   logic [bchr_pkg::CSR_DATA_W-1:0] wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- rtl/core/bchr_csr_regs.sv -----
`timescale 1ns / 1ps
// Configuration register file for the click/hold/repeat core.
// Depends on bchr_pkg and bchr_csr_if.
module bchr_csr_regs #(
   parameter int BUTTONS = bchr_pkg::DEFAULT_BUTTONS
) (
   input  logic                clock,
   input  logic                reset,
   bchr_csr_if.sink            csr_ch,
   output bchr_pkg::cfg_type   cfg,
   output logic [BUTTONS-1:0]  repeat_en_mask,
   output logic [BUTTONS-1:0]  hold_act_mask
);

   bchr_pkg::cfg_type  cfg_ff, cfg_in;
   logic [BUTTONS-1:0] rep_en_ff, rep_en_in;
   logic [BUTTONS-1:0] hold_act_ff, hold_act_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in      = cfg_ff;
      rep_en_in   = rep_en_ff;
      hold_act_in = hold_act_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.reg_index)
            bchr_pkg::CSR_SAMPLE_PERIOD:
               cfg_in.sample_period = csr_ch.wdata[bchr_pkg::PERIOD_W-1:0];
            bchr_pkg::CSR_DEBOUNCE: cfg_in.debounce    = csr_ch.wdata;
            bchr_pkg::CSR_HOLD:     cfg_in.hold        = csr_ch.wdata;
            bchr_pkg::CSR_REPEAT:   cfg_in.repeat_ival = csr_ch.wdata;
            bchr_pkg::CSR_REPEAT_EN: rep_en_in  = csr_ch.wdata[BUTTONS-1:0];
            bchr_pkg::CSR_HOLD_ACT:  hold_act_in = csr_ch.wdata[BUTTONS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_period <= bchr_pkg::RESET_SAMPLE_PERIOD;
         cfg_ff.debounce      <= bchr_pkg::RESET_DEBOUNCE;
         cfg_ff.hold          <= bchr_pkg::RESET_HOLD;
         cfg_ff.repeat_ival   <= bchr_pkg::RESET_REPEAT;
         rep_en_ff            <= BUTTONS'(bchr_pkg::RESET_REPEAT_EN);
         hold_act_ff          <= BUTTONS'(bchr_pkg::RESET_HOLD_ACT);
      end else begin
         cfg_ff      <= cfg_in;
         rep_en_ff   <= rep_en_in;
         hold_act_ff <= hold_act_in;
      end
   end

   assign cfg            = cfg_ff;
   assign repeat_en_mask = rep_en_ff;
   assign hold_act_mask  = hold_act_ff;

endmodule

// ----- rtl/core/bchr_lane.sv -----
`timescale 1ns / 1ps
// One button lane: debounce, hold and repeat timing for a single button.
// Depends on bchr_pkg.
module bchr_lane (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [bchr_pkg::NOW_W-1:0] now_ms,
   input  logic                       pressed,
   input  bchr_pkg::cfg_type          cfg,
   input  logic                       repeat_en,
   input  logic                       hold_act,
   output bchr_pkg::lane_res_type     res
);

   logic                       pressing_ff, pressing_in;
   logic                       deb_ff, deb_in;
   logic                       hold_fired_ff, hold_fired_in;
   logic                       click_ok_ff, click_ok_in;
   logic [bchr_pkg::NOW_W-1:0] press_start_ff, press_start_in;
   logic [bchr_pkg::NOW_W-1:0] last_rep_ff, last_rep_in;

   logic                       new_press;
   logic [bchr_pkg::NOW_W-1:0] held;
   logic [bchr_pkg::NOW_W-1:0] since_rep;
   logic                       deb_cur, hf_cur;
   logic                       click_evt, hold_evt;

   always_comb begin
      new_press = pressed && !pressing_ff;
      held      = new_press ? '0 : (now_ms - press_start_ff);
      since_rep = now_ms - last_rep_ff;
      deb_cur   = deb_ff && !new_press;
      hf_cur    = hold_fired_ff && !new_press;

      pressing_in    = pressing_ff;
      deb_in         = deb_ff;
      hold_fired_in  = hold_fired_ff;
      click_ok_in    = click_ok_ff;
      press_start_in = press_start_ff;
      last_rep_in    = last_rep_ff;
      click_evt      = 1'b0;
      hold_evt       = 1'b0;

      if (pressed) begin
         pressing_in    = 1'b1;
         press_start_in = new_press ? now_ms : press_start_ff;
         deb_in         = deb_cur;
         hold_fired_in  = hf_cur;
         click_ok_in    = click_ok_ff || new_press;
         if (!deb_cur) begin
            if (held >= bchr_pkg::NOW_W'(cfg.debounce)) begin
               deb_in      = 1'b1;
               last_rep_in = now_ms;
            end
         end else if (!hf_cur) begin
            if (repeat_en && hold_act && held >= bchr_pkg::NOW_W'(cfg.hold)) begin
               hold_evt      = 1'b1;
               hold_fired_in = 1'b1;
               last_rep_in   = now_ms;
               click_ok_in   = 1'b0;
            end
         end else if (repeat_en && hold_act &&
                      since_rep >= bchr_pkg::NOW_W'(cfg.repeat_ival)) begin
            hold_evt    = 1'b1;
            last_rep_in = now_ms;
         end
      end else begin
         // release: report a click if the press was debounced and no hold fired
         click_evt     = deb_ff && !hold_fired_ff && click_ok_ff;
         pressing_in   = 1'b0;
         deb_in        = 1'b0;
         hold_fired_in = 1'b0;
         click_ok_in   = 1'b1;
      end

      res.click    = click_evt;
      res.hold     = hold_evt;
      res.deb_cur  = deb_ff;
      res.deb_next = deb_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressing_ff   <= 1'b0;
         deb_ff        <= 1'b0;
         hold_fired_ff <= 1'b0;
         click_ok_ff   <= 1'b1;
      end else if (step) begin
         pressing_ff   <= pressing_in;
         deb_ff        <= deb_in;
         hold_fired_ff <= hold_fired_in;
         click_ok_ff   <= click_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         press_start_ff <= press_start_in;
         last_rep_ff    <= last_rep_in;
      end
   end

endmodule

// ----- rtl/core/bchr_merge.sv -----
`timescale 1ns / 1ps
// Merge stage: packs lane results into event vectors and holds the result register.
// Depends on bchr_pkg and bchr_rsp_if.
module bchr_merge #(
   parameter int BUTTONS = bchr_pkg::DEFAULT_BUTTONS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic                   sampled,
   input  bchr_pkg::lane_res_type lane_res [BUTTONS],
   output logic                   can_load,
   bchr_rsp_if.source             rsp_ch
);

   logic               valid_ff, valid_in;
   logic               sampled_ff;
   logic [BUTTONS-1:0] click_ff, click_in;
   logic [BUTTONS-1:0] hold_ff, hold_in;
   logic [BUTTONS-1:0] deb_ff, deb_in;

   always_comb begin
      for (int i = 0; i < BUTTONS; i++) begin
         click_in[i] = sampled && lane_res[i].click;
         hold_in[i]  = sampled && lane_res[i].hold;
         deb_in[i]   = sampled ? lane_res[i].deb_next : lane_res[i].deb_cur;
      end
   end

   // Free the register when empty or when its transfer completes this cycle
   assign can_load = !valid_ff || rsp_ch.ready;
   assign valid_in = load || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sampled_ff <= sampled;
         click_ff   <= click_in;
         hold_ff    <= hold_in;
         deb_ff     <= deb_in;
      end
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.sampled       = sampled_ff;
   assign rsp_ch.click_events  = click_ff;
   assign rsp_ch.hold_events   = hold_ff;
   assign rsp_ch.debounced_now = deb_ff;

endmodule

// ----- rtl/core/button_click_hold_repeat_core.sv -----
`timescale 1ns / 1ps
// Top level of the button debounce / long-press / auto-repeat core.
// Depends on bchr_pkg, the three channel interfaces, bchr_csr_regs, bchr_lane, bchr_merge.
//
// Usage:
//   req_ch carries one sample per transfer: now_ms (wrapping ms time) and the
//   active-high pressed vector. rsp_ch returns exactly one result per request:
//   sampled, click_events, hold_events and debounced_now. csr_ch writes one
//   configuration register per transfer and is always ready; write it only
//   while no request is in flight.
//   The result appears in the output register in the cycle after the
//   request transfer. Throughput: one request per cycle while the output
//   register is free, as each per-button lane computes its update combinationally
//   (one subtract and compare per lane plus the sample-period gate ahead of them).
//   Stall: req_ch.ready drops only while a result sits in the output register
//   and rsp_ch.ready is low; it rises again in the cycle the result is taken.
//   Reset: configuration returns to its default values, every lane forgets its
//   press, the last sample time is zero and no result is pending.
module button_click_hold_repeat_core #(
   parameter int BUTTONS = bchr_pkg::DEFAULT_BUTTONS
) (
   input  logic       clock,
   input  logic       reset,
   bchr_req_if.sink   req_ch,
   bchr_rsp_if.source rsp_ch,
   bchr_csr_if.sink   csr_ch
);

   bchr_pkg::cfg_type          cfg;
   logic [BUTTONS-1:0]         repeat_en_mask;
   logic [BUTTONS-1:0]         hold_act_mask;
   bchr_pkg::lane_res_type     lane_res [BUTTONS];

   logic [bchr_pkg::NOW_W-1:0] last_sample_ff, last_sample_in;
   logic                       accept;
   logic                       can_load;
   logic                       sample_ok;
   logic                       step;

   bchr_csr_regs #(.BUTTONS(BUTTONS)) u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_ch         (csr_ch),
      .cfg            (cfg),
      .repeat_en_mask (repeat_en_mask),
      .hold_act_mask  (hold_act_mask)
   );

   // Sample-period gate: act on the item only once enough time has passed
   assign sample_ok = (req_ch.now_ms - last_sample_ff) >=
                      bchr_pkg::NOW_W'(cfg.sample_period);

   assign req_ch.ready = can_load;
   assign accept       = req_ch.valid && can_load;
   assign step         = accept && sample_ok;

   assign last_sample_in = step ? req_ch.now_ms : last_sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_sample_ff <= '0;
      end else begin
         last_sample_ff <= last_sample_in;
      end
   end

   // One lane per button, all advancing on the same gated transfer
   for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
      bchr_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .step      (step),
         .now_ms    (req_ch.now_ms),
         .pressed   (req_ch.pressed[g]),
         .cfg       (cfg),
         .repeat_en (repeat_en_mask[g]),
         .hold_act  (hold_act_mask[g]),
         .res       (lane_res[g])
      );
   end

   bchr_merge #(.BUTTONS(BUTTONS)) u_merge (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .sampled  (sample_ok),
      .lane_res (lane_res),
      .can_load (can_load),
      .rsp_ch   (rsp_ch)
   );

   // A button never clicks and fires a hold in the same result
   a_click_hold_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((rsp_ch.click_events & rsp_ch.hold_events) == '0))
      else $error("click and hold reported for the same button");

   // A gated-out item carries no events
   a_gated_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.sampled) |->
         (rsp_ch.click_events == '0 && rsp_ch.hold_events == '0))
      else $error("events reported on a gated-out item");

   // A clicked button has just been released, so it cannot read as debounced
   a_click_released: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((rsp_ch.click_events & rsp_ch.debounced_now) == '0))
      else $error("click reported on a button still debounced");

   // Every accepted request shows up as a pending result in the next cycle
   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> rsp_ch.valid)
      else $error("accepted request produced no result");

endmodule

// ----- verif/tb_button_click_hold_repeat_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for button_click_hold_repeat_core.
// Predicts every result from its own model of the debounce/hold/repeat rules.
// Depends on bchr_pkg, bchr_req_if, bchr_rsp_if, bchr_csr_if and the core RTL.
module tb_button_click_hold_repeat_core;

   localparam int NB          = bchr_pkg::DEFAULT_BUTTONS;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_STALL  = 80;
   // Indexes past the last register: writes there must change nothing
   localparam logic [bchr_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [bchr_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [bchr_pkg::NOW_W-1:0] now_ms;
      logic [NB-1:0]              pressed;
   } sample_type;

   typedef struct packed {
      logic          sampled;
      logic [NB-1:0] clicks;
      logic [NB-1:0] holds;
      logic [NB-1:0] debounced;
   } button_events_type;

   logic clock;
   logic reset;

   bchr_req_if #(.BUTTONS(NB)) req_ch ();
   bchr_rsp_if #(.BUTTONS(NB)) rsp_ch ();
   bchr_csr_if                 csr_ch ();

   button_click_hold_repeat_core #(.BUTTONS(NB)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // ------------------------------------------------------------------
   // Button model: configuration copy and per-button press state
   // ------------------------------------------------------------------
   logic [bchr_pkg::PERIOD_W-1:0]   cfg_period;
   logic [bchr_pkg::TIME_CFG_W-1:0] cfg_debounce;
   logic [bchr_pkg::TIME_CFG_W-1:0] cfg_hold;
   logic [bchr_pkg::TIME_CFG_W-1:0] cfg_repeat;
   logic [NB-1:0]                   cfg_repeat_en;
   logic [NB-1:0]                   cfg_hold_act;

   logic [bchr_pkg::NOW_W-1:0] btn_last_sample;
   logic [bchr_pkg::NOW_W-1:0] btn_press_start [NB];
   logic [bchr_pkg::NOW_W-1:0] btn_last_repeat [NB];
   logic                       btn_pressing    [NB];
   logic                       btn_debounced   [NB];
   logic                       btn_hold_fired  [NB];
   logic                       btn_click_ok    [NB];

   // Scoreboard and traffic bookkeeping
   button_events_type expected_events_q[$];
   sample_type        sample_queue[$];
   int                total_queued;
   int                results_checked;
   int                mismatch_count;
   int                cycle_count;

   // Handshake flags, written only by the monitor at the rising edge
   bit req_fired;
   bit csr_fired;

   // Stimulus controls, written by the stimulus process at the rising edge
   bit idle_enabled;
   bit long_stall_armed;

   // Driver-side bookkeeping
   int req_gap;
   int req_mode_left;
   bit req_idle_mode;
   int rsp_gap;
   int rsp_mode_left;
   bit rsp_idle_mode;
   int long_stall_left;
   bit long_stall_done;

   // Stimulus generator state: running timestamp and which buttons are down
   logic [bchr_pkg::NOW_W-1:0] stim_time;
   logic [NB-1:0]              stim_down;

   // Return the model to its post-reset state, defaults included
   task automatic reset_button_model();
      cfg_period      = bchr_pkg::RESET_SAMPLE_PERIOD;
      cfg_debounce    = bchr_pkg::RESET_DEBOUNCE;
      cfg_hold        = bchr_pkg::RESET_HOLD;
      cfg_repeat      = bchr_pkg::RESET_REPEAT;
      cfg_repeat_en   = NB'(bchr_pkg::RESET_REPEAT_EN);
      cfg_hold_act    = NB'(bchr_pkg::RESET_HOLD_ACT);
      btn_last_sample = '0;
      for (int i = 0; i < NB; i++) begin
         btn_press_start[i] = '0;
         btn_last_repeat[i] = '0;
         btn_pressing[i]    = 1'b0;
         btn_debounced[i]   = 1'b0;
         btn_hold_fired[i]  = 1'b0;
         btn_click_ok[i]    = 1'b1;
      end
   endtask

   // Mirror a register write; upper data bits and spare indexes drop out
   task automatic apply_register_write(input logic [bchr_pkg::CSR_IDX_W-1:0] idx,
                                       input logic [bchr_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         bchr_pkg::CSR_SAMPLE_PERIOD: cfg_period    = data[bchr_pkg::PERIOD_W-1:0];
         bchr_pkg::CSR_DEBOUNCE:      cfg_debounce  = data[bchr_pkg::TIME_CFG_W-1:0];
         bchr_pkg::CSR_HOLD:          cfg_hold      = data[bchr_pkg::TIME_CFG_W-1:0];
         bchr_pkg::CSR_REPEAT:        cfg_repeat    = data[bchr_pkg::TIME_CFG_W-1:0];
         bchr_pkg::CSR_REPEAT_EN:     cfg_repeat_en = data[NB-1:0];
         bchr_pkg::CSR_HOLD_ACT:      cfg_hold_act  = data[NB-1:0];
         default: ;
      endcase
   endtask

   // Advance the model by one sample and return the events it causes
   function automatic button_events_type predict_button_events(
      input logic [bchr_pkg::NOW_W-1:0] now,
      input logic [NB-1:0]              pr);
      button_events_type          r;
      logic [bchr_pkg::NOW_W-1:0] since;
      logic [bchr_pkg::NOW_W-1:0] held;
      logic [bchr_pkg::NOW_W-1:0] since_rep;
      r     = '0;
      since = now - btn_last_sample;
      // Gated samples leave every piece of state alone
      if (since >= bchr_pkg::NOW_W'(cfg_period)) begin
         r.sampled       = 1'b1;
         btn_last_sample = now;
         for (int i = 0; i < NB; i++) begin
            if (pr[i]) begin
               if (!btn_pressing[i]) begin
                  btn_pressing[i]    = 1'b1;
                  btn_press_start[i] = now;
                  btn_debounced[i]   = 1'b0;
                  btn_hold_fired[i]  = 1'b0;
                  btn_click_ok[i]    = 1'b1;
               end
               held      = now - btn_press_start[i];
               since_rep = now - btn_last_repeat[i];
               if (!btn_debounced[i]) begin
                  if (held >= bchr_pkg::NOW_W'(cfg_debounce)) begin
                     btn_debounced[i]   = 1'b1;
                     btn_last_repeat[i] = now;
                  end
               end else if (!btn_hold_fired[i]) begin
                  if (cfg_repeat_en[i] && cfg_hold_act[i] &&
                      held >= bchr_pkg::NOW_W'(cfg_hold)) begin
                     r.holds[i]         = 1'b1;
                     btn_hold_fired[i]  = 1'b1;
                     btn_last_repeat[i] = now;
                     btn_click_ok[i]    = 1'b0;
                  end
               end else if (cfg_repeat_en[i] && cfg_hold_act[i] &&
                            since_rep >= bchr_pkg::NOW_W'(cfg_repeat)) begin
                  r.holds[i]         = 1'b1;
                  btn_last_repeat[i] = now;
               end
            end else begin
               // Release: a debounced press with no hold behind it is a click
               if (btn_debounced[i] && !btn_hold_fired[i] && btn_click_ok[i])
                  r.clicks[i] = 1'b1;
               btn_pressing[i]   = 1'b0;
               btn_debounced[i]  = 1'b0;
               btn_hold_fired[i] = 1'b0;
               btn_click_ok[i]   = 1'b1;
            end
         end
      end
      for (int i = 0; i < NB; i++)
         r.debounced[i] = btn_debounced[i];
      return r;
   endfunction

   task automatic check_field(input string what,
                              input logic [bchr_pkg::NOW_W-1:0] exp_v,
                              input logic [bchr_pkg::NOW_W-1:0] act_v);
      if (exp_v !== act_v) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, what, exp_v, act_v);
      end
   endtask

   // ------------------------------------------------------------------
   // Clock and cycle limit
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL button_click_hold_repeat_core");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: sample every handshake at the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      button_events_type exp_r;
      req_fired = 1'b0;
      csr_fired = 1'b0;
      if (reset) begin
         reset_button_model();
      end else begin
         // Register writes land only while idle, so apply them right away
         if (csr_ch.valid && csr_ch.ready) begin
            csr_fired = 1'b1;
            apply_register_write(csr_ch.reg_index, csr_ch.wdata);
         end
         // Check a result transfer against the oldest expectation
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_events_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with nothing expected, expected none, actual 0x%0h",
                        $time, {rsp_ch.sampled, rsp_ch.click_events,
                                rsp_ch.hold_events, rsp_ch.debounced_now});
            end else begin
               exp_r = expected_events_q.pop_front();
               results_checked++;
               check_field("sampled", bchr_pkg::NOW_W'(exp_r.sampled),
                           bchr_pkg::NOW_W'(rsp_ch.sampled));
               check_field("click_events", bchr_pkg::NOW_W'(exp_r.clicks),
                           bchr_pkg::NOW_W'(rsp_ch.click_events));
               check_field("hold_events", bchr_pkg::NOW_W'(exp_r.holds),
                           bchr_pkg::NOW_W'(rsp_ch.hold_events));
               check_field("debounced_now", bchr_pkg::NOW_W'(exp_r.debounced),
                           bchr_pkg::NOW_W'(rsp_ch.debounced_now));
            end
         end
         // Predict the result of every accepted sample
         if (req_ch.valid && req_ch.ready) begin
            req_fired = 1'b1;
            expected_events_q.push_back(predict_button_events(req_ch.now_ms,
                                                              req_ch.pressed));
         end
      end
   end

   // ------------------------------------------------------------------
   // Request driver: present queued samples at the falling edge
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      sample_type pick;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fired) begin
         // Hold a presented sample until its transfer; only then move on
         if (req_gap > 0) begin
            req_gap--;
            req_ch.valid <= 1'b0;
         end else if (idle_enabled && req_idle_mode && $urandom_range(0, 5) == 0) begin
            req_gap = $urandom_range(1, 14) - 1;
            req_ch.valid <= 1'b0;
         end else if (sample_queue.size() != 0) begin
            pick = sample_queue.pop_front();
            req_ch.valid   <= 1'b1;
            req_ch.now_ms  <= pick.now_ms;
            req_ch.pressed <= pick.pressed;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
      // Alternate stretches with and without idle bursts
      if (req_mode_left == 0) begin
         req_idle_mode = ($urandom_range(0, 2) != 0);
         req_mode_left = $urandom_range(20, 200);
      end else begin
         req_mode_left--;
      end
   end

   // ------------------------------------------------------------------
   // Result sink: random back-pressure plus one long hold-off
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (long_stall_left > 0) begin
         long_stall_left--;
         if (long_stall_left == 0)
            long_stall_done = 1'b1;
         rsp_ch.ready <= 1'b0;
      end else if (long_stall_armed && !long_stall_done) begin
         // Block the output long enough for the input side to back up
         long_stall_left = LONG_STALL;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ch.ready <= 1'b0;
      end else if (idle_enabled && rsp_idle_mode && $urandom_range(0, 4) == 0) begin
         rsp_gap = $urandom_range(1, 14) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
      if (rsp_mode_left == 0) begin
         rsp_idle_mode = ($urandom_range(0, 2) != 0);
         rsp_mode_left = $urandom_range(20, 200);
      end else begin
         rsp_mode_left--;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic queue_sample(input logic [bchr_pkg::NOW_W-1:0] now,
                               input logic [NB-1:0] pr);
      sample_queue.push_back('{now_ms: now, pressed: pr});
      total_queued++;
   endtask

   // Wait at falling edges until every queued sample has its result back
   task automatic wait_for_drain();
      do @(negedge clock);
      while (results_checked != total_queued);
   endtask

   // Drive one register write and hold until its transfer; valid stays up
   task automatic write_csr(input logic [bchr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bchr_pkg::CSR_DATA_W-1:0] data);
      csr_ch.valid     <= 1'b1;
      csr_ch.reg_index <= idx;
      csr_ch.wdata     <= data;
      do @(negedge clock);
      while (!csr_fired);
   endtask

   // Drain, rewrite every register with junk in the unused bits, end at a
   // rising edge so the caller can queue the next phase
   task automatic configure(input logic [bchr_pkg::PERIOD_W-1:0] period,
                            input logic [bchr_pkg::TIME_CFG_W-1:0] deb,
                            input logic [bchr_pkg::TIME_CFG_W-1:0] hold_t,
                            input logic [bchr_pkg::TIME_CFG_W-1:0] rep,
                            input logic [NB-1:0] en,
                            input logic [NB-1:0] act);
      wait_for_drain();
      write_csr(bchr_pkg::CSR_SAMPLE_PERIOD, 16'({$urandom, period}));
      write_csr(bchr_pkg::CSR_DEBOUNCE,      deb);
      write_csr(bchr_pkg::CSR_HOLD,          hold_t);
      write_csr(bchr_pkg::CSR_REPEAT,        rep);
      write_csr(bchr_pkg::CSR_REPEAT_EN,     16'({$urandom, en}));
      write_csr(bchr_pkg::CSR_HOLD_ACT,      16'({$urandom, act}));
      write_csr(CSR_SPARE_LO,                16'($urandom));
      write_csr(CSR_SPARE_HI,                16'($urandom));
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly believable press/release traffic on a running clock, with some
   // stray samples, time jumps and single-sample bounces mixed in
   task automatic queue_random_samples(input int count, input int max_step);
      int            roll;
      logic [NB-1:0] pr;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         for (int b = 0; b < NB; b++)
            if ($urandom_range(0, 15) == 0)
               stim_down[b] = ~stim_down[b];
         if (roll < 5) begin
            queue_sample($urandom, NB'($urandom));
         end else begin
            if (roll < 9)
               stim_time = $urandom;
            else
               stim_time = stim_time + $urandom_range(0, max_step);
            pr = stim_down;
            if (roll >= 94)
               pr = pr ^ (NB'(1) << $urandom_range(0, NB - 1));
            queue_sample(stim_time, pr);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      logic [bchr_pkg::PERIOD_W-1:0]   r_period;
      logic [bchr_pkg::TIME_CFG_W-1:0] r_hold;

      // Drive every input to a known value from time zero
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.now_ms    = '0;
      req_ch.pressed   = '0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.reg_index = bchr_pkg::CSR_SAMPLE_PERIOD;
      csr_ch.wdata     = '0;
      idle_enabled     = 1'b1;
      long_stall_armed = 1'b0;
      long_stall_done  = 1'b0;
      long_stall_left  = 0;
      req_gap          = 0;
      rsp_gap          = 0;
      req_mode_left    = 0;
      rsp_mode_left    = 0;
      req_idle_mode    = 1'b1;
      rsp_idle_mode    = 1'b1;
      total_queued     = 0;
      results_checked  = 0;
      mismatch_count   = 0;
      cycle_count      = 0;
      stim_time        = '0;
      stim_down        = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: gating of early samples, debounce, hold on the
      // buttons that have both enable and action, repeat, then a release
      // that clicks the enabled button without a hold action and the
      // buttons without long-press at all
      queue_sample(32'd0,   5'h00);
      queue_sample(32'd4,   5'h1F);
      queue_sample(32'd5,   5'h1F);
      queue_sample(32'd40,  5'h1F);
      queue_sample(32'd700, 5'h1F);
      queue_sample(32'd800, 5'h1F);
      queue_sample(32'd850, 5'h00);
      // Press across the 2^32 wrap, with a sample landing at time zero and a
      // gated release that must still report the debounced status
      queue_sample(32'hFFFF_FFF0, 5'h01);
      queue_sample(32'h0000_0000, 5'h01);
      queue_sample(32'h0000_0020, 5'h01);
      queue_sample(32'h0000_0021, 5'h00);
      queue_sample(32'h0000_0030, 5'h00);
      queue_sample(32'hFFFF_FFFF, 5'h10);
      queue_sample(32'h0000_0040, 5'h10);

      // Zero thresholds: debounce at once, hold next, then repeat every
      // sample; the press begins at time zero
      configure(8'd0, 16'd0, 16'd0, 16'd0, 5'h1F, 5'h1F);
      queue_sample(32'd0, 5'h1F);
      queue_sample(32'd0, 5'h1F);
      queue_sample(32'd0, 5'h1F);
      queue_sample(32'd0, 5'h1F);
      queue_sample(32'd0, 5'h00);

      // Near-default timing with long-press on buttons 0, 2 and 4; stall the
      // result side for a long stretch while samples keep coming
      configure(8'd5, 16'd30, 16'd600, 16'd100, 5'h1F, 5'h15);
      long_stall_armed = 1'b1;
      stim_time = 32'd1000;
      queue_random_samples(250, 60);

      // Fast thresholds, no sample gate: holds and repeats fire often
      configure(8'd0, 16'($urandom_range(0, 3)), 16'd20, 16'd5,
                NB'($urandom), NB'($urandom));
      queue_random_samples(250, 8);

      // Every threshold at its maximum, running through the time wrap
      configure(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'h1F, 5'h1F);
      stim_time = 32'hFFFF_0000;
      queue_random_samples(200, 20000);

      // Random settings
      repeat (3) begin
         r_period = bchr_pkg::PERIOD_W'($urandom_range(0, 40));
         r_hold   = bchr_pkg::TIME_CFG_W'($urandom_range(0, 400));
         configure(r_period, 16'($urandom_range(0, 100)), r_hold,
                   16'($urandom_range(0, 100)), NB'($urandom), NB'($urandom));
         queue_random_samples(150, r_period + r_hold / 8 + 10);
      end

      // Last stretch at full rate on both sides
      configure(8'd3, 16'd10, 16'd60, 16'd15, 5'h1F, NB'($urandom));
      idle_enabled = 1'b0;
      queue_random_samples(200, 12);

      // Drain, give the output register time to show anything stray
      wait_for_drain();
      repeat (4) @(negedge clock);
      if (expected_events_q.size() != 0) begin
         mismatch_count++;
         $display("%0t: results missing, expected %0d more, actual 0",
                  $time, expected_events_q.size());
      end
      if (mismatch_count == 0) begin
         $display("PASS button_click_hold_repeat_core");
      end else begin
         $display("FAIL button_click_hold_repeat_core");
      end
      $finish;
   end

endmodule
